// ===== hdl/ofp_pkg.sv =====
// shared types and constants of the optical flash pre-cut
`default_nettype none

package ofp_pkg;

	localparam int BW_W        = 10;
	localparam int WIN_W       = 16;
	localparam int THR_W       = 24;
	localparam int TIME_W      = 20;
	localparam int PE_W        = 24;
	localparam int CHAN_W      = 5;
	localparam int SUB_SHIFT   = 4;
	localparam int DIFF_W      = TIME_W + 1;
	localparam int Q_W         = TIME_W - SUB_SHIFT;
	localparam int TOT_OUT_W   = 40;
	localparam int FIRST_W     = 6;
	localparam int COUNT_W     = 7;
	localparam int FRAC_BITS   = 16;
	localparam int FRAC_W      = FRAC_BITS + 1;
	localparam int FC_W        = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

	localparam logic [BW_W-1:0]        BIN_WIDTH_RST = 10'd16;
	localparam logic signed [WIN_W-1:0] WIN_START_RST = 16'sd0;
	localparam logic signed [WIN_W-1:0] WIN_END_RST   = 16'sd1023;
	localparam logic [THR_W-1:0]       THRESH_RST    = 24'd5120;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BIN_WIDTH,
		REG_WINDOW_START,
		REG_WINDOW_END,
		REG_COINC_THRESHOLD
	} cfg_reg_t;

	typedef struct packed {
		logic [BW_W-1:0]         bin_width;
		logic signed [WIN_W-1:0] window_start;
		logic signed [WIN_W-1:0] window_end;
		logic [THR_W-1:0]        coinc_threshold;
	} ofp_cfg_t;

	typedef struct packed {
		logic                     kind;
		logic                     in_win;
		logic signed [DIFF_W-1:0] diff;
		logic signed [TIME_W-1:0] peak_time;
		logic [PE_W-1:0]          hit_pe;
		logic [CHAN_W-1:0]        channel;
	} ofp_item_t;

	typedef struct packed {
		logic                 flash_found;
		logic [TOT_OUT_W-1:0] total_pe;
		logic [FIRST_W-1:0]   first_flash_bin;
		logic [COUNT_W-1:0]   flash_bin_count;
		logic [FRAC_W-1:0]    max_fraction;
		logic                 truncated;
	} ofp_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HIT_DIV,
		ST_HIT_RD,
		ST_HIT_WR,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_P2_RD,
		ST_P2_CHK,
		ST_P2_DIV,
		ST_P2_SRD,
		ST_P2_SWR,
		ST_MAX_RD,
		ST_MAX_EV,
		ST_FRAC_INIT,
		ST_FRAC,
		ST_DONE
	} ofp_state_t;

endpackage

`default_nettype wire

// ===== hdl/ofp_front.sv =====
// input queue that classifies hits against the beam window
`default_nettype none

module ofp_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire ofp_pkg::ofp_cfg_t                  cfg,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               kind,
	input  wire logic signed [ofp_pkg::TIME_W-1:0]  peak_time,
	input  wire logic [ofp_pkg::PE_W-1:0]           hit_pe,
	input  wire logic [ofp_pkg::CHAN_W-1:0]         channel,
	output logic                                    item_valid,
	output ofp_pkg::ofp_item_t                      item,
	input  wire logic                               item_pop
);
	import ofp_pkg::*;

	ofp_item_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QPTR_W:0]         cnt_q;
	logic signed [TIME_W-1:0] lo;
	logic signed [TIME_W-1:0] hi;
	ofp_item_t               new_item;
	logic                    do_push;
	logic                    do_pop;

	// window edges in sub-tick units
	assign lo = {cfg.window_start, 4'b0000};
	assign hi = {cfg.window_end, 4'b0000};

	always_comb begin
		new_item.kind      = kind;
		new_item.in_win    = (peak_time >= lo) && (peak_time <= hi);
		new_item.diff      = {peak_time[TIME_W-1], peak_time} - {lo[TIME_W-1], lo};
		new_item.peak_time = peak_time;
		new_item.hit_pe    = hit_pe;
		new_item.channel   = channel;
	end

	assign full       = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = queue_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ofp_back.sv =====
// event engine: hit store, binning, flash search, channel pass and fraction
`default_nettype none

module ofp_back #(
	parameter int MAX_HITS     = 1024,
	parameter int MAX_BINS     = 64,
	parameter int NUM_CHANNELS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ofp_pkg::ofp_cfg_t   cfg,
	input  wire logic                item_valid,
	input  wire ofp_pkg::ofp_item_t  item,
	output logic                     item_pop,
	input  wire logic                res_free,
	output logic                     res_load,
	output ofp_pkg::ofp_res_t        res
);
	import ofp_pkg::*;

	localparam int HA_W  = $clog2(MAX_HITS);
	localparam int HC_W  = $clog2(MAX_HITS + 1);
	localparam int BIN_W = $clog2(MAX_BINS);
	localparam int BC_W  = $clog2(MAX_BINS + 1);
	localparam int CH_W  = $clog2(NUM_CHANNELS);
	localparam int ACC_W = PE_W + HC_W;
	localparam int TOT_W = ACC_W + BC_W;
	localparam int LIM_W = BW_W + BC_W;
	localparam int CMP_W = (LIM_W > Q_W) ? LIM_W : Q_W;
	localparam int RW    = BW_W + 1;
	localparam int DC_W  = $clog2(BIN_W);
	localparam int ENT_W = TIME_W + PE_W + CHAN_W;

	ofp_state_t state_q, state_d;

	// stores
	logic [ENT_W-1:0] hit_mem [MAX_HITS];
	logic [ACC_W-1:0] hist_mem [MAX_BINS];
	logic [ACC_W-1:0] sum_mem [NUM_CHANNELS];
	logic [ENT_W-1:0] hit_rd_q;
	logic [ACC_W-1:0] hist_rd_q;
	logic [ACC_W-1:0] sum_rd_q;
	logic [MAX_BINS-1:0]     hist_vld_q;
	logic [MAX_BINS-1:0]     flash_mask_q;
	logic [NUM_CHANNELS-1:0] sum_vld_q;

	// event state
	logic [HC_W-1:0]  hit_count_q;
	logic [HC_W-1:0]  p2_idx_q;
	logic [BIN_W-1:0] scan_idx_q;
	logic [CH_W-1:0]  ch_idx_q;
	logic             ovf_q;
	logic             found_q;
	logic [TOT_W-1:0] total_q;
	logic [BIN_W-1:0] first_q;
	logic [BC_W-1:0]  count_q;
	logic [ACC_W-1:0] best_q;
	logic [FRAC_W-1:0] frac_q;
	logic [TOT_W-1:0] frem_q;
	logic [FC_W-1:0]  fcnt_q;
	logic [PE_W-1:0]  pe_q;

	// shared bin divider
	logic [RW-1:0]    div_rem_q;
	logic [BIN_W-1:0] div_num_q;
	logic [BIN_W-1:0] div_quo_q;
	logic [DC_W-1:0]  div_cnt_q;

	// combinational helpers
	logic [BW_W-1:0]          bw_eff;
	logic [LIM_W-1:0]         limit;
	logic [Q_W-1:0]           q_hit;
	logic signed [TIME_W-1:0] p2_t;
	logic [PE_W-1:0]          p2_pe;
	logic [CHAN_W-1:0]        p2_ch;
	logic signed [TIME_W-1:0] ws16;
	logic signed [DIFF_W-1:0] p2_diff;
	logic [DIFF_W-1:0]        p2_mag;
	logic                     p2_neg;
	logic [Q_W-1:0]           q_p2;
	logic [Q_W-1:0]           q_src;
	logic                     over;
	logic                     bin0_ok;
	logic                     chan_ok;
	logic [RW-1:0]            dtry;
	logic                     dge;
	logic [BIN_W-1:0]         quo_next;
	logic                     hit_full;
	logic [ACC_W-1:0]         scan_v;
	logic                     above;
	logic                     below;
	logic                     scan_stop;
	logic                     found_nxt;
	logic                     p2_done;
	logic [ACC_W-1:0]         max_v;
	logic [TOT_W:0]           fsh;
	logic                     fge;

	// memory controls from the output decode
	logic             hit_we;
	logic             hit_re;
	logic             hist_re;
	logic             hist_we;
	logic [BIN_W-1:0] hist_addr;
	logic [ACC_W-1:0] hist_wdata;
	logic             sum_re;
	logic             sum_we;
	logic [CH_W-1:0]  sum_addr;
	logic [ACC_W-1:0] sum_wdata;
	logic             clear_evt;

	assign bw_eff   = (cfg.bin_width == '0) ? BW_W'(1) : cfg.bin_width;
	assign limit    = LIM_W'(MAX_BINS) * LIM_W'(bw_eff);
	assign q_hit    = item.diff[Q_W+SUB_SHIFT-1:SUB_SHIFT];
	assign p2_t     = hit_rd_q[ENT_W-1 -: TIME_W];
	assign p2_pe    = hit_rd_q[CHAN_W +: PE_W];
	assign p2_ch    = hit_rd_q[CHAN_W-1:0];
	assign ws16     = {cfg.window_start, 4'b0000};
	assign p2_diff  = {p2_t[TIME_W-1], p2_t} - {ws16[TIME_W-1], ws16};
	assign p2_neg   = p2_diff[DIFF_W-1];
	assign p2_mag   = p2_neg ? DIFF_W'(-p2_diff) : DIFF_W'(p2_diff);
	assign q_p2     = p2_mag[Q_W+SUB_SHIFT-1:SUB_SHIFT];
	assign q_src    = (state_q == ST_IDLE) ? q_hit : q_p2;
	assign over     = CMP_W'(q_src) >= CMP_W'(limit);
	assign bin0_ok  = q_p2 < Q_W'(bw_eff);
	assign chan_ok  = int'(p2_ch) < NUM_CHANNELS;
	assign dtry     = {div_rem_q[RW-2:0], div_num_q[BIN_W-1]};
	assign dge      = dtry >= RW'(bw_eff);
	assign quo_next = {div_quo_q[BIN_W-2:0], dge};
	assign hit_full = hit_count_q >= HC_W'(MAX_HITS);
	assign scan_v   = hist_vld_q[scan_idx_q] ? hist_rd_q : '0;
	assign above    = scan_v > ACC_W'(cfg.coinc_threshold);
	assign below    = scan_v < ACC_W'(cfg.coinc_threshold);
	assign scan_stop = (below && found_q) || (scan_idx_q == BIN_W'(MAX_BINS - 1));
	assign found_nxt = found_q || above;
	assign p2_done  = (p2_idx_q == hit_count_q);
	assign max_v    = sum_vld_q[ch_idx_q] ? sum_rd_q : '0;
	assign fsh      = {frem_q, 1'b0};
	assign fge      = fsh >= {1'b0, total_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (item.kind) begin
						state_d = ST_SCAN_RD;
					end else if (!hit_full && item.in_win && !over) begin
						state_d = ST_HIT_DIV;
					end
				end
			end
			ST_HIT_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = ST_HIT_RD;
				end
			end
			ST_HIT_RD:  state_d = ST_HIT_WR;
			ST_HIT_WR:  state_d = ST_IDLE;
			ST_SCAN_RD: state_d = ST_SCAN_EV;
			ST_SCAN_EV: begin
				if (scan_stop) begin
					if (!found_nxt) begin
						state_d = ST_DONE;
					end else if (hit_count_q != '0) begin
						state_d = ST_P2_RD;
					end else begin
						state_d = ST_MAX_RD;
					end
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_P2_RD: state_d = ST_P2_CHK;
			ST_P2_CHK: begin
				if (chan_ok && !p2_neg && !over) begin
					state_d = ST_P2_DIV;
				end else if (chan_ok && p2_neg && bin0_ok && flash_mask_q[0]) begin
					state_d = ST_P2_SRD;
				end else begin
					state_d = p2_done ? ST_MAX_RD : ST_P2_RD;
				end
			end
			ST_P2_DIV: begin
				if (div_cnt_q == '0) begin
					if (flash_mask_q[quo_next]) begin
						state_d = ST_P2_SRD;
					end else begin
						state_d = p2_done ? ST_MAX_RD : ST_P2_RD;
					end
				end
			end
			ST_P2_SRD: state_d = ST_P2_SWR;
			ST_P2_SWR: state_d = p2_done ? ST_MAX_RD : ST_P2_RD;
			ST_MAX_RD: state_d = ST_MAX_EV;
			ST_MAX_EV: begin
				state_d = (ch_idx_q == CH_W'(NUM_CHANNELS - 1)) ? ST_FRAC_INIT : ST_MAX_RD;
			end
			ST_FRAC_INIT: begin
				state_d = (TOT_W'(best_q) >= total_q) ? ST_DONE : ST_FRAC;
			end
			ST_FRAC: begin
				if (fcnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output decode
	always_comb begin
		item_pop  = 1'b0;
		hit_we    = 1'b0;
		hit_re    = 1'b0;
		hist_re   = 1'b0;
		hist_we   = 1'b0;
		hist_addr = div_quo_q;
		sum_re    = 1'b0;
		sum_we    = 1'b0;
		sum_addr  = CH_W'(p2_ch);
		res_load  = 1'b0;
		clear_evt = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_pop = item_valid;
				hit_we   = item_valid && !item.kind && !hit_full;
			end
			ST_HIT_RD: hist_re = 1'b1;
			ST_HIT_WR: hist_we = 1'b1;
			ST_SCAN_RD: begin
				hist_re   = 1'b1;
				hist_addr = scan_idx_q;
			end
			ST_P2_RD:  hit_re = 1'b1;
			ST_P2_SRD: sum_re = 1'b1;
			ST_P2_SWR: sum_we = 1'b1;
			ST_MAX_RD: begin
				sum_re   = 1'b1;
				sum_addr = ch_idx_q;
			end
			ST_DONE: begin
				res_load  = res_free;
				clear_evt = res_free;
			end
			default: begin
				item_pop = 1'b0;
			end
		endcase
	end

	assign hist_wdata = (hist_vld_q[div_quo_q] ? hist_rd_q : '0) + ACC_W'(pe_q);
	assign sum_wdata  = (sum_vld_q[sum_addr] ? sum_rd_q : '0) + ACC_W'(p2_pe);

	always_ff @(posedge clk) begin
		if (hit_we) begin
			hit_mem[hit_count_q[HA_W-1:0]] <= {item.peak_time, item.hit_pe, item.channel};
		end
		if (hit_re) begin
			hit_rd_q <= hit_mem[p2_idx_q[HA_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_addr] <= hist_wdata;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[hist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_addr] <= sum_wdata;
		end
		if (sum_re) begin
			sum_rd_q <= sum_mem[sum_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hit_count_q  <= '0;
			p2_idx_q     <= '0;
			scan_idx_q   <= '0;
			ch_idx_q     <= '0;
			ovf_q        <= 1'b0;
			found_q      <= 1'b0;
			total_q      <= '0;
			first_q      <= '0;
			count_q      <= '0;
			best_q       <= '0;
			frac_q       <= '0;
			frem_q       <= '0;
			fcnt_q       <= '0;
			pe_q         <= '0;
			div_rem_q    <= '0;
			div_num_q    <= '0;
			div_quo_q    <= '0;
			div_cnt_q    <= '0;
			hist_vld_q   <= '0;
			flash_mask_q <= '0;
			sum_vld_q    <= '0;
		end else begin
			state_q <= state_d;
			if (hist_we) begin
				hist_vld_q[hist_addr] <= 1'b1;
			end
			if (sum_we) begin
				sum_vld_q[sum_addr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid && !item.kind) begin
						if (hit_full) begin
							ovf_q <= 1'b1;
						end else begin
							hit_count_q <= hit_count_q + 1'b1;
							if (item.in_win) begin
								if (over) begin
									ovf_q <= 1'b1;
								end else begin
									pe_q      <= item.hit_pe;
									div_rem_q <= RW'(q_src >> BIN_W);
									div_num_q <= q_src[BIN_W-1:0];
									div_quo_q <= '0;
									div_cnt_q <= DC_W'(BIN_W - 1);
								end
							end
						end
					end
					if (item_valid && item.kind) begin
						scan_idx_q <= '0;
						p2_idx_q   <= '0;
						ch_idx_q   <= '0;
					end
				end
				ST_HIT_DIV, ST_P2_DIV: begin
					div_rem_q <= dge ? (dtry - RW'(bw_eff)) : dtry;
					div_num_q <= div_num_q << 1;
					div_quo_q <= quo_next;
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				ST_SCAN_EV: begin
					if (above) begin
						flash_mask_q[scan_idx_q] <= 1'b1;
						total_q <= total_q + TOT_W'(scan_v);
						count_q <= count_q + 1'b1;
						found_q <= 1'b1;
						if (!found_q) begin
							first_q <= scan_idx_q;
						end
					end
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				ST_P2_RD: begin
					p2_idx_q <= p2_idx_q + 1'b1;
				end
				ST_P2_CHK: begin
					div_rem_q <= RW'(q_src >> BIN_W);
					div_num_q <= q_src[BIN_W-1:0];
					div_quo_q <= '0;
					div_cnt_q <= DC_W'(BIN_W - 1);
				end
				ST_MAX_EV: begin
					if (max_v > best_q) begin
						best_q <= max_v;
					end
					ch_idx_q <= ch_idx_q + 1'b1;
				end
				ST_FRAC_INIT: begin
					if (TOT_W'(best_q) >= total_q) begin
						frac_q <= FRAC_ONE;
					end else begin
						frac_q <= '0;
						frem_q <= TOT_W'(best_q);
						fcnt_q <= FC_W'(FRAC_BITS - 1);
					end
				end
				ST_FRAC: begin
					frem_q <= fge ? TOT_W'(fsh - {1'b0, total_q}) : TOT_W'(fsh);
					frac_q <= {frac_q[FRAC_W-2:0], fge};
					fcnt_q <= fcnt_q - 1'b1;
				end
				default: begin
					pe_q <= pe_q;
				end
			endcase
			if (clear_evt) begin
				hit_count_q  <= '0;
				ovf_q        <= 1'b0;
				found_q      <= 1'b0;
				total_q      <= '0;
				first_q      <= '0;
				count_q      <= '0;
				best_q       <= '0;
				frac_q       <= '0;
				hist_vld_q   <= '0;
				flash_mask_q <= '0;
				sum_vld_q    <= '0;
			end
		end
	end

	always_comb begin
		res.flash_found     = found_q;
		res.total_pe        = TOT_OUT_W'(total_q);
		res.first_flash_bin = FIRST_W'(first_q);
		res.flash_bin_count = COUNT_W'(count_q);
		res.max_fraction    = frac_q;
		res.truncated       = ovf_q;
	end

	a_hit_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q <= HC_W'(MAX_HITS))
		else $error("hit count beyond store depth");

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HIT_RD) |-> (int'(div_quo_q) < MAX_BINS))
		else $error("histogram bin out of range");

	a_frac_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (frac_q <= FRAC_ONE))
		else $error("fraction above one");

	a_no_flash: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && !found_q) |-> (total_q == '0 && count_q == '0 && frac_q == '0))
		else $error("flash data without flash");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (hit_count_q == '0 && hist_vld_q == '0 && flash_mask_q == '0))
		else $error("event state not cleared");

endmodule

`default_nettype wire

// ===== hdl/optical_flash_precut.sv =====
// top level of the optical flash pre-cut: config registers, front queue, engine, result register
// hit: the engine runs the bit-serial bin divider, then reads and writes back the histogram bin
// end of event: a scan of the histogram bins, a flash pass over the stored hits with the bin divider,
//   a pass over the channels for the maximum and the fraction divider, then the result register
// the front queue takes four items while the engine works; one result waits in the output register
// arst_n clears control state at once and loads the register defaults; stores use valid bits,
//   so no clearing pass follows reset
`default_nettype none

module optical_flash_precut #(
	parameter int MAX_HITS     = 1024,
	parameter int MAX_BINS     = 64,
	parameter int NUM_CHANNELS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// input transactions
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic                                 kind,
	input  wire logic signed [ofp_pkg::TIME_W-1:0]    peak_time,
	input  wire logic [ofp_pkg::PE_W-1:0]             hit_pe,
	input  wire logic [ofp_pkg::CHAN_W-1:0]           channel,
	// result transactions
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic                                      flash_found,
	output logic [ofp_pkg::TOT_OUT_W-1:0]             total_pe,
	output logic [ofp_pkg::FIRST_W-1:0]               first_flash_bin,
	output logic [ofp_pkg::COUNT_W-1:0]               flash_bin_count,
	output logic [ofp_pkg::FRAC_W-1:0]                max_fraction,
	output logic                                      truncated,
	// configuration writes
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ofp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ofp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ofp_pkg::*;

	ofp_cfg_t  cfg_q;
	ofp_item_t item;
	logic      item_valid;
	logic      item_pop;
	logic      res_free;
	logic      res_load;
	ofp_res_t  res;
	ofp_res_t  res_q;
	logic      res_valid_q;

	// register writes are always taken, the engine is idle by contract
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_width       <= BIN_WIDTH_RST;
			cfg_q.window_start    <= WIN_START_RST;
			cfg_q.window_end      <= WIN_END_RST;
			cfg_q.coinc_threshold <= THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_BIN_WIDTH:       cfg_q.bin_width       <= cfg_data[BW_W-1:0];
				REG_WINDOW_START:    cfg_q.window_start    <= cfg_data[WIN_W-1:0];
				REG_WINDOW_END:      cfg_q.window_end      <= cfg_data[WIN_W-1:0];
				REG_COINC_THRESHOLD: cfg_q.coinc_threshold <= cfg_data[THR_W-1:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	// front: accepts items, tags window membership and offset from the window start
	ofp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.kind       (kind),
		.peak_time  (peak_time),
		.hit_pe     (hit_pe),
		.channel    (channel),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	// back: stores hits, bins them and runs the end of event passes
	ofp_back #(
		.MAX_HITS     (MAX_HITS),
		.MAX_BINS     (MAX_BINS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.res_free   (res_free),
		.res_load   (res_load),
		.res        (res)
	);

	// one-deep result register; a new result may load in the cycle the old one leaves
	assign res_free = !res_valid_q || pop;

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	assign empty           = !res_valid_q;
	assign flash_found     = res_q.flash_found;
	assign total_pe        = res_q.total_pe;
	assign first_flash_bin = res_q.first_flash_bin;
	assign flash_bin_count = res_q.flash_bin_count;
	assign max_fraction    = res_q.max_fraction;
	assign truncated       = res_q.truncated;

endmodule

`default_nettype wire

// ===== tb/sv/tb_optical_flash_precut.sv =====
// self-checking testbench of the optical flash pre-cut: predictor, scoreboard and stimulus
`timescale 1ns / 100ps

// one input transaction as the sender sees it
typedef struct {
	bit                  kind;
	logic signed [19:0]  peak_time;
	logic [23:0]         hit_pe;
	logic [4:0]          channel;
} precut_item_t;

class flash_scoreboard;
	// predicted configuration
	int unsigned   bin_width;
	longint        window_start;
	longint        window_end;
	longint unsigned coinc_threshold;
	// predicted event state
	longint        stored_time[1024];
	longint unsigned stored_pe[1024];
	int            stored_chan[1024];
	int            stored_hits;
	longint unsigned bin_pe[64];
	bit            dropped;
	// expected flash summaries, oldest first
	ofp_pkg::ofp_res_t flash_q[$];
	int            errors;
	int            checked;

	function new();
		bin_width = 16;
		window_start = 0;
		window_end = 1023;
		coinc_threshold = 5120;
		errors = 0;
		checked = 0;
		clear_event();
	endfunction

	function void clear_event();
		stored_hits = 0;
		dropped = 0;
		foreach (bin_pe[i]) bin_pe[i] = 0;
	endfunction

	function void write_reg(ofp_pkg::cfg_reg_t idx, logic [23:0] data);
		case (idx)
			ofp_pkg::REG_BIN_WIDTH: bin_width = data[9:0];
			ofp_pkg::REG_WINDOW_START: window_start = $signed(data[15:0]);
			ofp_pkg::REG_WINDOW_END: window_end = $signed(data[15:0]);
			ofp_pkg::REG_COINC_THRESHOLD: coinc_threshold = data;
			default: ;
		endcase
	endfunction

	function longint bin_span();
		return (bin_width == 0) ? 16 : longint'(bin_width) * 16;
	endfunction

	function void note_item(precut_item_t it);
		longint t;
		longint b;
		if (!it.kind) begin
			t = it.peak_time;
			if (stored_hits >= 1024) begin
				dropped = 1;
				return;
			end
			stored_time[stored_hits] = t;
			stored_pe[stored_hits] = it.hit_pe;
			stored_chan[stored_hits] = it.channel;
			stored_hits++;
			if (t > window_end * 16 || t < window_start * 16)
				return;
			b = (t - window_start * 16) / bin_span();
			if (b >= 64) begin
				dropped = 1;
				return;
			end
			bin_pe[b] += it.hit_pe;
		end else begin
			summarize_event();
			clear_event();
		end
	endfunction

	function void summarize_event();
		bit              found;
		bit              in_flash[64];
		longint unsigned sums[32];
		longint unsigned total, best, frac;
		int              first, count;
		longint          b;
		ofp_pkg::ofp_res_t r;
		found = 0;
		total = 0;
		best = 0;
		frac = 0;
		first = 0;
		count = 0;
		foreach (in_flash[i]) in_flash[i] = 0;
		foreach (sums[i]) sums[i] = 0;
		// first run of bins above threshold; equal bins neither extend nor end it
		for (int i = 0; i < 64; i++) begin
			if (bin_pe[i] > coinc_threshold) begin
				if (!found) begin
					found = 1;
					first = i;
				end
				in_flash[i] = 1;
				total += bin_pe[i];
				count++;
			end else if (bin_pe[i] < coinc_threshold && found) begin
				break;
			end
		end
		if (found) begin
			// second pass truncates toward zero, so hits just before the window land in bin 0
			for (int i = 0; i < stored_hits; i++) begin
				b = (stored_time[i] - window_start * 16) / bin_span();
				if (b >= 0 && b < 64 && in_flash[b])
					sums[stored_chan[i]] += stored_pe[i];
			end
			foreach (sums[i]) if (sums[i] > best) best = sums[i];
			if (total != 0) begin
				frac = (best << 16) / total;
				if (frac > 65536) frac = 65536;
			end
		end
		r.flash_found = found;
		r.total_pe = total[39:0];
		r.first_flash_bin = first[5:0];
		r.flash_bin_count = count[6:0];
		r.max_fraction = frac[16:0];
		r.truncated = dropped;
		flash_q = {flash_q, r};
	endfunction

	function void check_result(ofp_pkg::ofp_res_t got);
		ofp_pkg::ofp_res_t exp_r;
		checked++;
		if (flash_q.size() == 0) begin
			$error("flash summary with no event pending");
			errors++;
			return;
		end
		exp_r = flash_q.pop_front();
		if (got.flash_found !== exp_r.flash_found) begin
			$error("flash_found expected %0d got %0d", exp_r.flash_found, got.flash_found);
			errors++;
		end
		if (got.total_pe !== exp_r.total_pe) begin
			$error("total_pe expected %0d got %0d", exp_r.total_pe, got.total_pe);
			errors++;
		end
		if (got.first_flash_bin !== exp_r.first_flash_bin) begin
			$error("first_flash_bin expected %0d got %0d",
				exp_r.first_flash_bin, got.first_flash_bin);
			errors++;
		end
		if (got.flash_bin_count !== exp_r.flash_bin_count) begin
			$error("flash_bin_count expected %0d got %0d",
				exp_r.flash_bin_count, got.flash_bin_count);
			errors++;
		end
		if (got.max_fraction !== exp_r.max_fraction) begin
			$error("max_fraction expected %0d got %0d", exp_r.max_fraction, got.max_fraction);
			errors++;
		end
		if (got.truncated !== exp_r.truncated) begin
			$error("truncated expected %0d got %0d", exp_r.truncated, got.truncated);
			errors++;
		end
	endfunction
endclass

module tb_optical_flash_precut;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 kind;
	logic signed [19:0]   peak_time;
	logic [23:0]          hit_pe;
	logic [4:0]           channel;
	logic                 empty;
	logic                 pop;
	logic                 flash_found;
	logic [39:0]          total_pe;
	logic [5:0]           first_flash_bin;
	logic [6:0]           flash_bin_count;
	logic [16:0]          max_fraction;
	logic                 truncated;
	logic                 cfg_valid;
	logic                 cfg_ready;
	ofp_pkg::cfg_reg_t    cfg_index;
	logic [23:0]          cfg_data;

	flash_scoreboard sb;
	int  items_sent;
	int  events_sent;
	int  cfg_writes;
	bit  quiet;      // no idling on either side near the end

	optical_flash_precut uut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .kind(kind), .peak_time(peak_time),
		.hit_pe(hit_pe), .channel(channel),
		.empty(empty), .pop(pop), .flash_found(flash_found), .total_pe(total_pe),
		.first_flash_bin(first_flash_bin), .flash_bin_count(flash_bin_count),
		.max_fraction(max_fraction), .truncated(truncated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// generous overall limit
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// send one transaction; called just after the clock rises, returns just after the clock that took it,
	// with push still high so that consecutive items need no glitch
	task automatic send_item(precut_item_t it);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push <= 1;
		kind <= it.kind;
		peak_time <= it.peak_time;
		hit_pe <= it.hit_pe;
		channel <= it.channel;
		do @(posedge clk); while (full);
		sb.note_item(it);
		items_sent++;
		if (it.kind) events_sent++;
	endtask

	task automatic send_hit(longint t, logic [23:0] pe, logic [4:0] ch);
		precut_item_t it;
		if (t > 524287) t = 524287;
		if (t < -524288) t = -524288;
		it.kind = 0;
		it.peak_time = t[19:0];
		it.hit_pe = pe;
		it.channel = ch;
		send_item(it);
	endtask

	// end of event carries random junk in the hit fields
	task automatic send_eoe();
		precut_item_t it;
		it.kind = 1;
		it.peak_time = 20'($urandom);
		it.hit_pe = 24'($urandom);
		it.channel = 5'($urandom);
		send_item(it);
	endtask

	// wait until every summary is back and the engine has had time to settle
	task automatic drain();
		push <= 0;
		do @(posedge clk); while (sb.flash_q.size() != 0);
		repeat (80) @(posedge clk);
	endtask

	// valid stays high across consecutive writes and is dropped by the caller
	task automatic write_cfg(ofp_pkg::cfg_reg_t idx, logic [23:0] data);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
	endtask

	task automatic set_config(int unsigned bw, int ws, int we, int unsigned thr);
		write_cfg(ofp_pkg::REG_BIN_WIDTH, 24'(bw));
		write_cfg(ofp_pkg::REG_WINDOW_START, 24'(ws[15:0]));
		write_cfg(ofp_pkg::REG_WINDOW_END, 24'(we[15:0]));
		write_cfg(ofp_pkg::REG_COINC_THRESHOLD, 24'(thr));
		cfg_valid <= 0;
	endtask

	// hit PE relative to the current threshold so flashes are neither always nor never found
	function automatic logic [23:0] pick_pe();
		longint unsigned thr;
		thr = sb.coinc_threshold;
		case ($urandom_range(0, 3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 255));
			default: return (thr > 24'hFFFFFF / 2) ? 24'($urandom) :
				24'($urandom_range(0, 32'(2 * thr + 16)));
		endcase
	endfunction

	// hit time mostly near the binned range of the window, some before, past and anywhere
	function automatic longint pick_time();
		longint lo;
		longint span;
		lo = sb.window_start * 16;
		span = sb.bin_span();
		case ($urandom_range(0, 9))
			0: return $signed(20'($urandom));
			1: return lo - $urandom_range(1, 2 * span);
			2: return lo + span * 64 + $urandom_range(0, span * 4);
			default: return lo + $urandom_range(0, span * 8) +
				span * $urandom_range(0, 60);
		endcase
	endfunction

	task automatic random_event(int n);
		int ch_base;
		ch_base = $urandom_range(0, 31);
		for (int i = 0; i < n; i++) begin
			// mostly a few dominant channels, sometimes any channel
			if ($urandom_range(0, 2) == 0)
				send_hit(pick_time(), pick_pe(), 5'($urandom));
			else
				send_hit(pick_time(), pick_pe(), 5'(ch_base + $urandom_range(0, 2)));
		end
		send_eoe();
	endtask

	// result side: pop with random stall bursts, check on each accepted transaction
	initial begin
		int stall;
		ofp_pkg::ofp_res_t got;
		stall = 0;
		pop = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				got.flash_found = flash_found;
				got.total_pe = total_pe;
				got.first_flash_bin = first_flash_bin;
				got.flash_bin_count = flash_bin_count;
				got.max_fraction = max_fraction;
				got.truncated = truncated;
				sb.check_result(got);
			end
			if (quiet) begin
				stall = 0;
			end else if (stall == 0 && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 11);
			end
			if (stall > 0) begin
				pop <= 0;
				stall--;
			end else begin
				pop <= 1;
			end
		end
	end

	initial begin
		sb = new();
		items_sent = 0;
		events_sent = 0;
		cfg_writes = 0;
		quiet = 0;
		arst_n = 0;
		push = 0;
		kind = 0;
		peak_time = 0;
		hit_pe = 0;
		channel = 0;
		cfg_valid = 0;
		cfg_index = ofp_pkg::REG_BIN_WIDTH;
		cfg_data = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed, reset config: 16-tick bins, window 0..1023, threshold 5120
		send_hit(0, 24'd5120, 5'd0);          // bin 0 equal to threshold, skipped
		send_hit(256, 24'd6000, 5'd1);        // bin 1 starts the run
		send_hit(300, 24'd100, 5'd1);
		send_hit(512, 24'd5120, 5'd2);        // equal bin inside the run, skipped
		send_hit(768, 24'hFFFFFF, 5'd31);     // largest PE
		send_hit(1024, 24'd10, 5'd3);         // below threshold ends the run
		send_hit(1280, 24'd9000, 5'd3);       // after the run, not counted
		send_hit(16368, 24'd100, 5'd4);       // window end, inclusive
		send_hit(16369, 24'd7000, 5'd4);      // just past window end
		send_hit(-524288, 24'd0, 5'd5);
		send_hit(524287, 24'd1, 5'd6);
		send_eoe();
		// hit just before the window joins bin 0 in the second pass: fraction saturates
		send_hit(10, 24'd6000, 5'd4);
		send_hit(-3, 24'hFFFFFF, 5'd4);
		send_eoe();
		send_eoe();                           // event with no hits
		drain();
		// zero bin width and an empty window
		set_config(0, 100, 50, 5120);
		send_hit(1600, 24'hFFFFFF, 5'd7);
		send_eoe();
		drain();
		// narrowest bins, widest window, zero threshold; hit past the last bin
		set_config(1, -32768, 32767, 0);
		send_hit(-524288, 24'd1, 5'd8);
		send_hit(-524288 + 16 * 70, 24'd50, 5'd9);
		send_eoe();
		drain();
		// widest bins, top threshold
		set_config(1023, -32768, 32767, 24'hFFFFFF);
		send_hit(0, 24'hFFFFFF, 5'd10);
		send_eoe();
		drain();

		// hit store overflow at reset-like settings
		set_config(16, 0, 1023, 5120);
		random_event(1030);
		drain();

		// random phases of settings, each a batch of short well-formed events
		while (items_sent < 1650) begin
			case ($urandom_range(0, 4))
				0: set_config($urandom_range(0, 1023), $signed(16'($urandom)),
					$signed(16'($urandom)), $urandom);
				1: set_config($urandom_range(1, 4), -$urandom_range(0, 64),
					$urandom_range(0, 300), $urandom_range(0, 3000));
				default: set_config($urandom_range(1, 64), $signed(16'($urandom)) / 4,
					32767, $urandom_range(0, 40000));
			endcase
			if (items_sent > 1500) quiet = 1;
			repeat ($urandom_range(2, 6)) begin
				random_event($urandom_range(0, 14));
				if (items_sent > 1500) quiet = 1;
			end
			drain();
		end

		quiet = 1;
		drain();
		repeat (200) @(posedge clk);
		$display("covered %0d items in %0d events over %0d register writes",
			items_sent, events_sent, cfg_writes);
		$display("checked %0d flash summaries, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.flash_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ===== optical_flash_precut.f =====
hdl/ofp_pkg.sv
hdl/ofp_front.sv
hdl/ofp_back.sv
hdl/optical_flash_precut.sv
tb/sv/tb_optical_flash_precut.sv
